// ===== hdl/mpct_pkg.sv =====
// package for the mouse packet cursor tracker
// widths, reset values, register indexes, packet struct and button encoder
// no dependencies
package mpct_pkg;

    localparam int BYTE_W   = 8;
    localparam int POS_W    = 12;
    localparam int BTN_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int SUM_W    = POS_W + 2;

    localparam logic [POS_W-1:0] RESET_X_LIMIT = 12'd1004;
    localparam logic [POS_W-1:0] RESET_Y_LIMIT = 12'd748;
    localparam logic [POS_W-1:0] RESET_POS_X   = 12'd512;
    localparam logic [POS_W-1:0] RESET_POS_Y   = 12'd384;

    // bit of the first packet byte that marks packet start
    localparam int SYNC_BIT = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_LIMIT = 2'd0,
        CFG_Y_LIMIT = 2'd1
    } cfg_idx_t;

    // slot of the next byte inside a packet
    typedef enum logic [1:0] {
        SLOT_FIRST  = 2'd0,
        SLOT_SECOND = 2'd1,
        SLOT_THIRD  = 2'd2,
        SLOT_UNUSED = 2'd3
    } slot_t;

    // button codes
    typedef enum logic [BTN_W-1:0] {
        BTN_NONE = 3'd0,
        BTN_L    = 3'd1,
        BTN_R    = 3'd2,
        BTN_M    = 3'd3,
        BTN_LR   = 3'd4,
        BTN_LRM  = 3'd5
    } btn_code_t;

    // completed packet offered by the assembler
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] first;
        logic [BYTE_W-1:0] second;
        logic [BYTE_W-1:0] third;
    } pkt_t;

    // limits held by the configuration registers
    typedef struct packed {
        logic [POS_W-1:0] x_limit;
        logic [POS_W-1:0] y_limit;
    } limits_t;

    // priority encoder for the button bits (bit0 L, bit1 R, bit2 M)
    function automatic logic [BTN_W-1:0] encode_buttons(input logic [BYTE_W-1:0] b);
        logic l;
        logic r;
        logic m;
        logic [BTN_W-1:0] code;
        l = b[0];
        r = b[1];
        m = b[2];
        if (l && r && m)
            code = BTN_LRM;
        else if (l && r)
            code = BTN_LR;
        else if (r)
            code = BTN_R;
        else if (m)
            code = BTN_M;
        else if (l)
            code = BTN_L;
        else
            code = BTN_NONE;
        return code;
    endfunction

endpackage

// ===== hdl/mpct_if.sv =====
// channel interfaces for the mouse packet cursor tracker
// received byte, cursor result and configuration write channels; uses mpct_pkg

interface mpct_byte_if
    import mpct_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mpct_result_if
    import mpct_pkg::*;
    ();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] cursor_x;
    logic [POS_W-1:0] cursor_y;
    logic [BTN_W-1:0] button_code;
    logic [BTN_W-1:0] prev_button_code;

    modport source (output valid, output cursor_x, output cursor_y,
                    output button_code, output prev_button_code, input ready);
    modport sink   (input valid, input cursor_x, input cursor_y,
                    input button_code, input prev_button_code, output ready);
endinterface

interface mpct_cfg_if
    import mpct_pkg::*;
    ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [POS_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/mouse_packet_cursor_tracker.sv =====
// a packet's third byte sits in the input register; its result enters the result
// register once free; one byte per cycle, set by the input/result register pair;
// bytes keep flowing while a result waits unless a third byte finds it full
// reset: asynchronous, active low; cursor at 512/384, limits 1004/748,
// button codes none, assembler waits for a first byte with the sync bit
module mouse_packet_cursor_tracker
    import mpct_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    mpct_byte_if.sink     rx,
    mpct_cfg_if.sink      cfg,
    mpct_result_if.source cursor
);

    limits_t limits;
    pkt_t    pkt;
    logic    pkt_ready;

    // limit registers
    mpct_cfg_regs u_cfg_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .limits (limits)
    );

    // byte capture and packet assembly
    mpct_assembler u_assembler (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .pkt       (pkt),
        .pkt_ready (pkt_ready)
    );

    // cursor update and result register
    mpct_cursor u_cursor (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt       (pkt),
        .pkt_ready (pkt_ready),
        .limits    (limits),
        .cursor    (cursor)
    );

endmodule

// ===== hdl/mpct_cfg_regs.sv =====
// configuration registers: cursor x and y limits
// uses mpct_pkg and mpct_cfg_if
module mpct_cfg_regs
    import mpct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mpct_cfg_if.sink    cfg,
    output limits_t     limits
);

    logic [POS_W-1:0] x_limit_reg;
    logic [POS_W-1:0] y_limit_reg;
    logic             wr_en;

    // writes are always taken
    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid;

    // limit registers, writes beyond the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_limit_reg <= RESET_X_LIMIT;
            y_limit_reg <= RESET_Y_LIMIT;
        end
        else if (wr_en)
        begin
            case (cfg.index)
                CFG_X_LIMIT: x_limit_reg <= cfg.data;
                CFG_Y_LIMIT: y_limit_reg <= cfg.data;
                default:     ;
            endcase
        end
    end

    assign limits.x_limit = x_limit_reg;
    assign limits.y_limit = y_limit_reg;

endmodule

// ===== hdl/mpct_assembler.sv =====
// input register and packet assembly with sync on the first byte
// uses mpct_pkg and mpct_byte_if
module mpct_assembler
    import mpct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mpct_byte_if.sink   rx,
    output pkt_t        pkt,
    input  logic        pkt_ready
);

    logic              byte_valid_reg;
    logic              byte_valid_next;
    logic [BYTE_W-1:0] byte_reg;
    slot_t             slot_reg;
    slot_t             slot_next;
    logic [BYTE_W-1:0] first_reg;
    logic [BYTE_W-1:0] first_next;
    logic [BYTE_W-1:0] second_reg;
    logic [BYTE_W-1:0] second_next;
    logic              completes;
    logic              consume;
    logic              rx_xfer;

    // held byte finishes a packet when it sits in the third slot
    assign completes = byte_valid_reg && (slot_reg == SLOT_THIRD);
    assign consume   = byte_valid_reg && (!completes || pkt_ready);
    assign rx.ready  = !byte_valid_reg || consume;
    assign rx_xfer   = rx.valid && rx.ready;

    assign pkt.valid  = completes;
    assign pkt.first  = first_reg;
    assign pkt.second = second_reg;
    assign pkt.third  = byte_reg;

    // slot tracking on each consumed byte
    always_comb
    begin
        slot_next   = slot_reg;
        first_next  = first_reg;
        second_next = second_reg;
        if (consume)
        begin
            case (slot_reg)
                SLOT_SECOND:
                begin
                    second_next = byte_reg;
                    slot_next   = SLOT_THIRD;
                end
                SLOT_THIRD:
                begin
                    slot_next = SLOT_FIRST;
                end
                default:
                begin
                    if (byte_reg[SYNC_BIT])
                    begin
                        first_next = byte_reg;
                        slot_next  = SLOT_SECOND;
                    end
                    else
                    begin
                        slot_next = SLOT_FIRST;
                    end
                end
            endcase
        end
    end

    // input register occupancy
    always_comb
    begin
        byte_valid_next = byte_valid_reg;
        if (rx_xfer)
            byte_valid_next = 1'b1;
        else if (consume)
            byte_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            slot_reg       <= SLOT_FIRST;
            first_reg      <= '0;
            second_reg     <= '0;
        end
        else
        begin
            byte_valid_reg <= byte_valid_next;
            slot_reg       <= slot_next;
            first_reg      <= first_next;
            second_reg     <= second_next;
        end
    end

    // input payload register
    always_ff @(posedge clk)
    begin
        if (rx_xfer)
            byte_reg <= rx.rx_byte;
    end

endmodule

// ===== hdl/mpct_cursor.sv =====
// cursor update: add deltas, clamp to limits, encode buttons, result register
// uses mpct_pkg and mpct_result_if
module mpct_cursor
    import mpct_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  pkt_t          pkt,
    output logic          pkt_ready,
    input  limits_t       limits,
    mpct_result_if.source cursor
);

    logic              res_valid_reg;
    logic              res_valid_next;
    logic [POS_W-1:0]  pos_x_reg;
    logic [POS_W-1:0]  pos_x_next;
    logic [POS_W-1:0]  pos_y_reg;
    logic [POS_W-1:0]  pos_y_next;
    logic [BTN_W-1:0]  cur_btn_reg;
    logic [BTN_W-1:0]  last_btn_reg;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic              fire;

    // result register is free or drains this cycle
    assign pkt_ready = !res_valid_reg || cursor.ready;
    assign fire      = pkt.valid && pkt_ready;

    // x adds the delta, y subtracts it (screen y grows downward)
    assign sum_x = $signed({2'b00, pos_x_reg})
                 + $signed({{(SUM_W-BYTE_W){pkt.second[BYTE_W-1]}}, pkt.second});
    assign sum_y = $signed({2'b00, pos_y_reg})
                 - $signed({{(SUM_W-BYTE_W){pkt.third[BYTE_W-1]}}, pkt.third});

    // clamp to 0..limit
    always_comb
    begin
        if (sum_x[SUM_W-1])
            pos_x_next = '0;
        else if (sum_x[SUM_W-2:0] > {1'b0, limits.x_limit})
            pos_x_next = limits.x_limit;
        else
            pos_x_next = sum_x[POS_W-1:0];

        if (sum_y[SUM_W-1])
            pos_y_next = '0;
        else if (sum_y[SUM_W-2:0] > {1'b0, limits.y_limit})
            pos_y_next = limits.y_limit;
        else
            pos_y_next = sum_y[POS_W-1:0];
    end

    // result valid flag
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (fire)
            res_valid_next = 1'b1;
        else if (cursor.ready)
            res_valid_next = 1'b0;
    end

    // position and button state doubles as the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            pos_x_reg     <= RESET_POS_X;
            pos_y_reg     <= RESET_POS_Y;
            cur_btn_reg   <= BTN_NONE;
            last_btn_reg  <= BTN_NONE;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (fire)
            begin
                pos_x_reg    <= pos_x_next;
                pos_y_reg    <= pos_y_next;
                last_btn_reg <= cur_btn_reg;
                cur_btn_reg  <= encode_buttons(pkt.first);
            end
        end
    end

    assign cursor.valid            = res_valid_reg;
    assign cursor.cursor_x         = pos_x_reg;
    assign cursor.cursor_y         = pos_y_reg;
    assign cursor.button_code      = cur_btn_reg;
    assign cursor.prev_button_code = last_btn_reg;

endmodule

// ===== hdl/mpct_checker.sv =====
// port-level checks for the mouse packet cursor tracker
// uses mpct_pkg; bound to the top level below
module mpct_checker
    import mpct_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             rx_valid,
    input logic             rx_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [POS_W-1:0] cursor_x,
    input logic [POS_W-1:0] cursor_y,
    input logic [BTN_W-1:0] button_code,
    input logic [BTN_W-1:0] prev_button_code
);

    // a stalled result holds its valid and payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cursor_x) && $stable(cursor_y)
            && $stable(button_code) && $stable(prev_button_code))
        else $error("result changed while stalled");

    // button codes stay within the encoding
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> button_code <= BTN_LRM && prev_button_code <= BTN_LRM)
        else $error("button code out of range");

    // the byte side only backs up behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !rx_ready |-> out_valid && !out_ready)
        else $error("byte input stalled without a waiting result");

    // no result is offered right after reset
    assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid out of reset");

endmodule

bind mouse_packet_cursor_tracker mpct_checker u_mpct_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .rx_valid         (rx.valid),
    .rx_ready         (rx.ready),
    .out_valid        (cursor.valid),
    .out_ready        (cursor.ready),
    .cursor_x         (cursor.cursor_x),
    .cursor_y         (cursor.cursor_y),
    .button_code      (cursor.button_code),
    .prev_button_code (cursor.prev_button_code)
);

// ===== tb/sv/mouse_packet_cursor_tracker_tb.sv =====
// testbench for the mouse packet cursor tracker: byte stream in, cursor results out
// scoreboard class predicts cursor position and button codes per packet
// depends on mpct_pkg, the mpct channel interfaces and mouse_packet_cursor_tracker
module mouse_packet_cursor_tracker_tb;
    import mpct_pkg::*;

    localparam int LONG_HOLD      = 64;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 7;
    localparam int PHASE_ITEMS    = 136;
    localparam int REPORT_MAX     = 10;

    // one cursor result as seen on the output channel
    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [BTN_W-1:0] btn;
        logic [BTN_W-1:0] prev;
    } cursor_rec_t;

    // packet assembler and cursor predictor with a queue of expected cursor results
    class cursor_scoreboard;
        logic [POS_W-1:0]  x_lim;
        logic [POS_W-1:0]  y_lim;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        slot_t             slot;
        logic [BYTE_W-1:0] first_b;
        logic [BYTE_W-1:0] second_b;
        btn_code_t         btn_now;
        btn_code_t         btn_prev;
        cursor_rec_t       cursor_q[$];
        int                errors;
        int                packets;

        function new();
            x_lim    = RESET_X_LIMIT;
            y_lim    = RESET_Y_LIMIT;
            pos_x    = RESET_POS_X;
            pos_y    = RESET_POS_Y;
            slot     = SLOT_FIRST;
            first_b  = '0;
            second_b = '0;
            btn_now  = BTN_NONE;
            btn_prev = BTN_NONE;
            errors   = 0;
            packets  = 0;
        endfunction

        function void set_limit(cfg_idx_t idx, logic [POS_W-1:0] v);
            if (idx == CFG_X_LIMIT)
                x_lim = v;
            else if (idx == CFG_Y_LIMIT)
                y_lim = v;
        endfunction

        function logic [POS_W-1:0] clamp_to(int v, logic [POS_W-1:0] lim);
            int l;
            l = lim;
            if (v < 0)
                return '0;
            if (v > l)
                return lim;
            return POS_W'(v);
        endfunction

        // advance the assembler by one accepted byte
        function void note_byte(logic [BYTE_W-1:0] b);
            int px;
            int py;
            int dx;
            int dy;
            cursor_rec_t rec;
            case (slot)
                SLOT_SECOND:
                begin
                    second_b = b;
                    slot = SLOT_THIRD;
                end
                SLOT_THIRD:
                begin
                    px = pos_x;
                    py = pos_y;
                    dx = $signed(second_b);
                    dy = $signed(b);
                    pos_x = clamp_to(px + dx, x_lim);
                    pos_y = clamp_to(py - dy, y_lim);
                    btn_prev = btn_now;
                    // priority: all three, left with right, right, middle, left
                    if (first_b[0] && first_b[1] && first_b[2])
                        btn_now = BTN_LRM;
                    else if (first_b[0] && first_b[1])
                        btn_now = BTN_LR;
                    else if (first_b[1])
                        btn_now = BTN_R;
                    else if (first_b[2])
                        btn_now = BTN_M;
                    else if (first_b[0])
                        btn_now = BTN_L;
                    else
                        btn_now = BTN_NONE;
                    slot = SLOT_FIRST;
                    rec.x    = pos_x;
                    rec.y    = pos_y;
                    rec.btn  = btn_now;
                    rec.prev = btn_prev;
                    cursor_q.push_back(rec);
                end
                default:
                begin
                    // a first byte without the sync bit is dropped
                    if (b[SYNC_BIT])
                    begin
                        first_b = b;
                        slot = SLOT_SECOND;
                    end
                    else
                        slot = SLOT_FIRST;
                end
            endcase
        endfunction

        // compare one result transfer with the oldest expectation
        function void check_result(cursor_rec_t got);
            cursor_rec_t want;
            if (cursor_q.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected result x=%0d y=%0d btn=%0d prev=%0d",
                             got.x, got.y, got.btn, got.prev);
                return;
            end
            want = cursor_q.pop_front();
            packets++;
            if (got.x !== want.x || got.y !== want.y ||
                got.btn !== want.btn || got.prev !== want.prev)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("mismatch packet %0d: want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                             packets, want.x, want.y, want.btn, want.prev,
                             got.x, got.y, got.btn, got.prev);
            end
        endfunction

        function int pending();
            return cursor_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    mpct_byte_if   rx_if ();
    mpct_cfg_if    cfg_if ();
    mpct_result_if cur_if ();

    mouse_packet_cursor_tracker dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_if),
        .cfg    (cfg_if),
        .cursor (cur_if)
    );

    cursor_scoreboard sb = new();

    bit idle_on;
    bit hold_off_req;
    int bytes_sent;
    int cfg_writes;
    int idle_cycles;
    int hold_left;
    int stall_left;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver ready: long hold on request, short random stalls while idling is on
    initial
    begin
        hold_left    = 0;
        stall_left   = 0;
        cur_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_left = LONG_HOLD;
                hold_off_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                cur_if.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                cur_if.ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                cur_if.ready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end
            else
                cur_if.ready <= 1'b1;
        end
    end

    // result monitor
    initial
    begin
        cursor_rec_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && cur_if.valid && cur_if.ready)
            begin
                got.x    = cur_if.cursor_x;
                got.y    = cur_if.cursor_y;
                got.btn  = cur_if.button_code;
                got.prev = cur_if.prev_button_code;
                sb.check_result(got);
            end
        end
    end

    // watchdog on cycles with no transfer on any channel
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((rx_if.valid && rx_if.ready) || (cfg_if.valid && cfg_if.ready) ||
                (cur_if.valid && cur_if.ready) || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                         idle_cycles, sb.pending());
                $display("mouse_packet_cursor_tracker_tb NOT OK");
                $finish;
            end
        end
    end

    // offer one byte, with a random gap in front when idling is on
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            rx_if.valid   <= 1'b0;
            rx_if.rx_byte <= BYTE_W'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (!rx_if.ready) @(posedge clk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic offer_packet(input logic [BYTE_W-1:0] f, input logic [BYTE_W-1:0] s,
                                input logic [BYTE_W-1:0] t);
        send_byte(f);
        send_byte(s);
        send_byte(t);
    endtask

    // stop offering and wait until every expected result has arrived
    task automatic drain_results();
        @(negedge clk);
        rx_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input cfg_idx_t idx, input logic [POS_W-1:0] v);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= v;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        sb.set_limit(idx, v);
        cfg_writes++;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // delta for one axis; drift pushes toward a clamp, otherwise uniform
    function automatic logic [BYTE_W-1:0] pick_delta(input int drift);
        if (drift == 0 || $urandom_range(0, 3) == 0)
            return BYTE_W'($urandom);
        if (drift > 0)
            return BYTE_W'($urandom_range(8'h40, 8'h7f));
        return BYTE_W'($urandom_range(8'h80, 8'hc0));
    endfunction

    // mostly well-formed packets, some unsynced noise and stray bytes
    task automatic random_bytes(input int count, input int drift);
        int n;
        int pick;
        n = 0;
        while (n < count)
        begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
            begin
                send_byte(BYTE_W'($urandom) & ~(8'h01 << SYNC_BIT));
                n += 1;
            end
            else if (pick == 1)
            begin
                send_byte(BYTE_W'($urandom));
                n += 1;
            end
            else
            begin
                // x moves with the drift, y against it since y is subtracted
                offer_packet(BYTE_W'($urandom) | (8'h01 << SYNC_BIT),
                             pick_delta(drift), pick_delta(-drift));
                n += 3;
            end
        end
    endtask

    // stimulus
    initial
    begin
        logic [POS_W-1:0] xl;
        logic [POS_W-1:0] yl;
        rst_n          = 1'b0;
        rx_if.valid    = 1'b0;
        rx_if.rx_byte  = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = CFG_X_LIMIT;
        cfg_if.data    = '0;
        idle_on        = 1'b1;
        hold_off_req   = 1'b0;
        bytes_sent     = 0;
        cfg_writes     = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // unsynced first bytes, full-scale deltas, button combinations at reset limits
        send_byte(8'h00);
        send_byte(8'hf7);
        offer_packet(8'h08, 8'h7f, 8'h80);
        offer_packet(8'h09, 8'h80, 8'h7f);
        offer_packet(8'h0a, 8'h00, 8'hff);
        offer_packet(8'h0c, 8'hff, 8'h00);
        offer_packet(8'h0d, 8'h01, 8'h01);
        drain_results();

        // limits lowered below the current position
        write_limit(CFG_X_LIMIT, 12'd100);
        write_limit(CFG_Y_LIMIT, 12'd50);
        offer_packet(8'h0b, 8'h05, 8'hfb);
        drain_results();
        write_limit(CFG_X_LIMIT, 12'd0);
        write_limit(CFG_Y_LIMIT, 12'd0);
        offer_packet(8'hff, 8'h80, 8'h7f);
        drain_results();
        write_limit(CFG_X_LIMIT, 12'hfff);
        write_limit(CFG_Y_LIMIT, 12'hfff);
        offer_packet(8'h0e, 8'h7f, 8'h80);

        // random phases, each with its own limits
        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            case (p)
                0:
                begin
                    xl = 12'hfff;
                    yl = 12'hfff;
                end
                1:
                begin
                    xl = 12'd0;
                    yl = 12'd0;
                end
                3:
                begin
                    xl = POS_W'($urandom_range(1, 200));
                    yl = POS_W'($urandom_range(1, 200));
                end
                5:
                begin
                    xl = RESET_X_LIMIT;
                    yl = RESET_Y_LIMIT;
                end
                default:
                begin
                    xl = POS_W'($urandom);
                    yl = POS_W'($urandom);
                end
            endcase
            write_limit(CFG_X_LIMIT, xl);
            if (p != 4)
                write_limit(CFG_Y_LIMIT, yl);
            // receiver holds off for a long stretch while bytes keep coming
            if (p == 2)
                hold_off_req = 1'b1;
            idle_on = (p != PHASES - 1);
            random_bytes(PHASE_ITEMS, (p % 3) - 1);
        end
        drain_results();

        $display("covered %0d bytes, %0d packets checked, %0d limit writes",
                 bytes_sent, sb.packets, cfg_writes);
        $display("limits ranged from zero to full scale, with a long output stall and drains");
        if (sb.pending() != 0)
            $display("%0d expected results never arrived", sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("mouse_packet_cursor_tracker_tb OK");
        else
            $display("mouse_packet_cursor_tracker_tb NOT OK");
        $finish;
    end

endmodule
